// ===== src/peu_pkg.sv =====
// Package for the particle emitter update block: request/result types,
// configuration register indexes, fixed-point constants and saturation helpers.
// No dependencies.
`default_nettype none

package peu_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 32;

  localparam int unsigned DT_W    = 20;
  localparam int unsigned SEED_W  = 16;
  localparam int unsigned LIFE_W  = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFE_SPAN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_INTERVAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_RANGE   = 3'd7;

  // floor(2^35 / 25): reciprocal for the jitter scale |x| * 8192 / 25
  localparam logic [30:0] REC_25  = 31'd1374389534;
  localparam int unsigned REC_SHIFT = 35;

  typedef struct packed {
    logic [DT_W-1:0]   elapsed_time;
    logic [SEED_W-1:0] random_seed;
  } peu_req_t;

  typedef struct packed {
    logic [4:0]         slot_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [LIFE_W-1:0]  life_left;
    logic               respawned;
    logic               last_item;
  } peu_res_t;

  typedef struct packed {
    logic [LIFE_W-1:0]  life;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } peu_slot_t;

  function automatic logic signed [31:0] sat_33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_48(input logic signed [47:0] x);
    logic signed [31:0] r;
    if ((&x[47:31]) || !(|x[47:31])) begin
      r = x[31:0];
    end else begin
      r = x[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/particle_emitter_update_top.sv =====
// Particle emitter update: slot walk, jitter, Euler integration, spawning.
// Depends on peu_pkg (types, register indexes, constants, saturation helpers).
`default_nettype none

// How to use this block
// - Request channel: drive req_i and raise start; the request is taken at the
//   rising edge where start is high and busy is low. One request is one tick
//   (elapsed time dt in Q4.16 and a seed for the 16-bit jitter LFSR).
// - Results: one result per live slot, in ascending slot order, each shown on
//   res_o for exactly one cycle with res_valid_o high. The receiver cannot
//   stall; it must take every result in the cycle it appears. last_item marks
//   the final result of a tick; a tick with no live slot gives no result.
// - Configuration: write cfg_data_i to register cfg_idx_i with cfg_we_i high,
//   only while busy is low. No read-back.
// - Slot walk: the slot state lives in one memory with a registered read
//   port. A free slot is passed over. A live slot is read, then worked
//   through three axes, each bounded by the 16-step serial modulo of the
//   LFSR draw and the shared 32x32 multiplier used three times per axis,
//   then written back.
// - Results lag one slot behind the walk so the last one can carry last_item;
//   the final result appears in the cycle busy falls.
// - Reset: live bits, spawn timer, LFSR and registers take their reset
//   values at once; slot memory contents are written before they are read,
//   so no clearing pass is needed.
module particle_emitter_update_top #(
  parameter int unsigned MAX_PARTICLES = peu_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire peu_pkg::peu_req_t                  req_i,
  output logic                                    res_valid_o,
  output peu_pkg::peu_res_t                       res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [peu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [peu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import peu_pkg::*;

  localparam int unsigned IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_DRAW = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_JIT  = 4'd5;
  localparam logic [3:0] S_JWT  = 4'd6;
  localparam logic [3:0] S_QCOR = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_AWT  = 4'd9;
  localparam logic [3:0] S_DEL  = 4'd10;
  localparam logic [3:0] S_DWT  = 4'd11;
  localparam logic [3:0] S_VEL  = 4'd12;
  localparam logic [3:0] S_POS  = 4'd13;
  localparam logic [3:0] S_WB   = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  // configuration registers
  logic [5:0]          max_count_q;
  logic [LIFE_W-1:0]   life_span_q;
  logic signed [31:0]  speed_q;
  logic signed [31:0]  dir_x_q, dir_y_q, dir_z_q;
  logic [LIFE_W-1:0]   spawn_int_q;
  logic [15:0]         jrange_q;

  // control state
  logic [3:0]              state_q;
  logic [MAX_PARTICLES-1:0] live_q;
  logic signed [32:0]      timer_q;
  logic [15:0]             lfsr_q;
  logic [CNT_W-1:0]        slot_q;
  logic [CNT_W-1:0]        live_cnt_q;
  logic [IDX_W-1:0]        free_q;
  logic                    free_found_q;
  logic [1:0]              k_q;
  logic [4:0]              div_cnt_q;
  logic                    pend_v_q;
  logic                    res_valid_q;

  // payload / datapath registers
  logic [DT_W-1:0]     dt_q;
  peu_slot_t           rd_q;
  logic [LIFE_W-1:0]   life_q;
  logic                resp_q;
  logic signed [31:0]  pos_q [3];
  logic signed [31:0]  vel_q [3];
  logic [15:0]         dvd_q;
  logic [16:0]         rem_q;
  logic [29:0]         n_q;
  logic                neg_q;
  logic [25:0]         jq_q;
  logic signed [31:0]  op_a_q, op_b_q;
  logic signed [63:0]  prod_q;
  peu_res_t            pend_q;
  peu_res_t            res_q;

  peu_slot_t           mem_q [MAX_PARTICLES];

  logic [IDX_W-1:0]    idx;
  logic                rd_en;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  peu_slot_t           wr_data;
  logic signed [63:0]  prod_d;
  logic [6:0]          limit;
  logic                spawn_ok;
  logic [15:0]         lfsr_nxt;
  logic [16:0]         modulus;
  logic [17:0]         div_t;
  logic [31:0]         life_diff;
  logic [17:0]         jx;
  logic [17:0]         jax;
  logic [25:0]         q0;
  logic [30:0]         q25;
  logic [30:0]         qrem;
  logic signed [32:0]  jit33;
  logic signed [31:0]  dir_k;
  logic signed [33:0]  timer_sub;
  logic signed [31:0]  mul_sat;

  assign idx      = slot_q[IDX_W-1:0];
  assign prod_d   = op_a_q * op_b_q;
  assign mul_sat  = sat_48(prod_q[63:16]);
  assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign modulus  = {1'b0, jrange_q} + 17'd1;
  assign div_t    = {rem_q, dvd_q[15]};
  assign life_diff = {1'b0, rd_q.life} - {12'b0, dt_q};
  assign jx       = {rem_q, 1'b0} - {1'b0, modulus};
  assign jax      = jx[17] ? (18'd0 - jx) : jx;
  assign q0       = prod_q[REC_SHIFT+25:REC_SHIFT];
  assign q25      = ({5'b0, q0} << 4) + ({5'b0, q0} << 3) + {5'b0, q0};
  assign qrem     = {1'b0, n_q} - q25;
  assign jit33    = neg_q ? (33'sd0 - $signed({7'b0, jq_q})) : $signed({7'b0, jq_q});
  assign timer_sub = {timer_q[32], timer_q} - $signed({14'b0, req_i.elapsed_time});
  assign limit    = ({1'b0, max_count_q} > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES)
                                                             : {1'b0, max_count_q};
  assign spawn_ok = (7'(live_cnt_q) < limit) && timer_q[32] && free_found_q;
  assign rd_en    = (state_q == S_SCAN) && (slot_q != CNT_W'(MAX_PARTICLES)) && live_q[idx];

  always_comb begin
    case (k_q)
      2'd0:    dir_k = dir_x_q;
      2'd1:    dir_k = dir_y_q;
      default: dir_k = dir_z_q;
    endcase
  end

  // memory write port: slot write-back or spawn
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '{life: life_q, pos_x: pos_q[0], pos_y: pos_q[1], pos_z: pos_q[2],
                vel_x: vel_q[0], vel_y: vel_q[1], vel_z: vel_q[2]};
    case (state_q)
      S_WB: begin
        wr_en = 1'b1;
      end
      S_FIN: begin
        wr_en   = spawn_ok;
        wr_addr = free_q;
        wr_data = '{life: life_span_q, default: '0};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx];
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= '0;
      life_span_q <= LIFE_W'(65536);
      speed_q     <= 32'sd65536;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      dir_z_q     <= '0;
      spawn_int_q <= '0;
      jrange_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_COUNT:      max_count_q <= cfg_data_i[5:0];
        CFG_LIFE_SPAN:      life_span_q <= cfg_data_i[LIFE_W-1:0];
        CFG_SPEED_GAIN:     speed_q     <= cfg_data_i;
        CFG_DIR_X:          dir_x_q     <= cfg_data_i;
        CFG_DIR_Y:          dir_y_q     <= cfg_data_i;
        CFG_DIR_Z:          dir_z_q     <= cfg_data_i;
        CFG_SPAWN_INTERVAL: spawn_int_q <= cfg_data_i[LIFE_W-1:0];
        CFG_JITTER_RANGE:   jrange_q    <= cfg_data_i[15:0];
        default:            max_count_q <= max_count_q;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // payload registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dt_q <= req_i.elapsed_time;
      end
      S_LOAD: begin
        if (life_diff[31]) begin
          life_q <= life_span_q;
          resp_q <= 1'b1;
          pos_q  <= '{default: '0};
          vel_q  <= '{default: '0};
        end else begin
          life_q <= life_diff[LIFE_W-1:0];
          resp_q <= 1'b0;
          pos_q  <= '{rd_q.pos_x, rd_q.pos_y, rd_q.pos_z};
          vel_q  <= '{rd_q.vel_x, rd_q.vel_y, rd_q.vel_z};
        end
      end
      S_DRAW: begin
        dvd_q <= lfsr_nxt;
        rem_q <= '0;
      end
      S_DIV: begin
        // one restoring step of lfsr mod (range + 1)
        dvd_q <= {dvd_q[14:0], 1'b0};
        if (div_t >= {1'b0, modulus}) begin
          rem_q <= 17'(div_t - {1'b0, modulus});
        end else begin
          rem_q <= div_t[16:0];
        end
      end
      S_JIT: begin
        // |2v - m| * 8192, divided by 25 through the reciprocal
        n_q    <= {jax[16:0], 13'b0};
        neg_q  <= jx[17];
        op_a_q <= $signed({2'b0, jax[16:0], 13'b0});
        op_b_q <= $signed({1'b0, REC_25});
      end
      S_QCOR: begin
        jq_q <= (qrem >= 31'd25) ? (q0 + 26'd1) : q0;
      end
      S_ACC: begin
        op_a_q <= sat_33({dir_k[31], dir_k} + jit33);
        op_b_q <= speed_q;
      end
      S_DEL: begin
        op_a_q <= mul_sat;
        op_b_q <= $signed({12'b0, dt_q});
      end
      S_VEL: begin
        vel_q[k_q] <= sat_33({vel_q[k_q][31], vel_q[k_q]} + {mul_sat[31], mul_sat});
      end
      S_POS: begin
        pos_q[k_q] <= sat_33({pos_q[k_q][31], pos_q[k_q]} + {vel_q[k_q][31], vel_q[k_q]});
      end
      S_WB: begin
        pend_q <= '{slot_index: 5'(idx), pos_x: pos_q[0], pos_y: pos_q[1],
                    pos_z: pos_q[2], life_left: life_q, respawned: resp_q,
                    last_item: 1'b0};
      end
      default: begin
        dt_q <= dt_q;
      end
    endcase
    // release the held result; mark it final when the walk is over
    if ((state_q == S_WB) || (state_q == S_FIN)) begin
      res_q <= '{slot_index: pend_q.slot_index, pos_x: pend_q.pos_x,
                 pos_y: pend_q.pos_y, pos_z: pend_q.pos_z,
                 life_left: pend_q.life_left, respawned: pend_q.respawned,
                 last_item: (state_q == S_FIN)};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      live_q       <= '0;
      timer_q      <= '0;
      lfsr_q       <= 16'd1;
      slot_q       <= '0;
      live_cnt_q   <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      k_q          <= '0;
      div_cnt_q    <= '0;
      pend_v_q     <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            lfsr_q       <= (req_i.random_seed != '0) ? req_i.random_seed : 16'd1;
            // hold the timer at its floor of -2^32
            timer_q      <= (timer_sub < -34'sd4294967296) ? -33'sd4294967296
                                                           : timer_sub[32:0];
            slot_q       <= '0;
            live_cnt_q   <= '0;
            free_found_q <= 1'b0;
            pend_v_q     <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (slot_q == CNT_W'(MAX_PARTICLES)) begin
            state_q <= S_FIN;
          end else if (live_q[idx]) begin
            state_q <= S_LOAD;
          end else begin
            if (!free_found_q) begin
              free_q       <= idx;
              free_found_q <= 1'b1;
            end
            slot_q <= slot_q + CNT_W'(1);
          end
        end
        S_LOAD: begin
          live_cnt_q <= live_cnt_q + CNT_W'(1);
          k_q        <= '0;
          state_q    <= S_DRAW;
        end
        S_DRAW: begin
          lfsr_q    <= lfsr_nxt;
          div_cnt_q <= 5'd16;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == 5'd1) begin
            state_q <= S_JIT;
          end
        end
        S_JIT:  state_q <= S_JWT;
        S_JWT:  state_q <= S_QCOR;
        S_QCOR: state_q <= S_ACC;
        S_ACC:  state_q <= S_AWT;
        S_AWT:  state_q <= S_DEL;
        S_DEL:  state_q <= S_DWT;
        S_DWT:  state_q <= S_VEL;
        S_VEL:  state_q <= S_POS;
        S_POS: begin
          if (k_q == 2'd2) begin
            state_q <= S_WB;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_DRAW;
          end
        end
        S_WB: begin
          // release the previous result, hold this one until the next
          res_valid_q <= pend_v_q;
          pend_v_q    <= 1'b1;
          slot_q      <= slot_q + CNT_W'(1);
          state_q     <= S_SCAN;
        end
        S_FIN: begin
          res_valid_q <= pend_v_q;
          pend_v_q    <= 1'b0;
          if (spawn_ok) begin
            timer_q        <= $signed({2'b0, spawn_int_q});
            live_q[free_q] <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the walk");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_item) |-> !busy)
    else $error("final result while the walk is still running");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q != 5'd0))
    else $error("modulo step count ran out");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= CNT_W'(MAX_PARTICLES))
    else $error("live count above slot count");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> busy)
    else $error("slot memory written while idle");
`endif

endmodule

`default_nettype wire
